// ===== rtl/cvf_pkg.sv =====
// cvf_pkg: shared constants for the cut vertex finder.
// Used by cut_vertex_finder_core; no dependencies.
package cvf_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int ROW_W            = 32;
    localparam int FIELD_W          = 6;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;

    localparam logic [APB_ADDR_W-3:0] REG_VERTEX_COUNT = '0;
    localparam logic [FIELD_W-1:0]    VERTEX_COUNT_RST = 6'd32;

endpackage

// ===== rtl/cut_vertex_finder_core.sv =====
// cut_vertex_finder_core: brute force articulation point search on a bit-row
// adjacency matrix, using one shared reachability unit and a small sequencer.
// Depends on cvf_pkg.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_row_bits
//  result    out        o_out_valid / i_out_stall  vertex number, cut flag, totals
//  config    in/out     APB (psel, penable, ...)   vertex_count at byte address 0
//
// Rows are written into the store as they arrive; the row that completes the matrix starts the
// analysis, and o_in_stall stays high until the last result is loaded.
// Analysis runs V+1 reachability passes. A pass reads one row per frontier vertex,
// waits for the last read to merge, seeds each new component and then closes;
// each removal pass adds an emit step.
// Reset clears control state and sets vertex_count to 32; the matrix store has
// no reset. A stalled result holds the sequencer before the next removal pass.
module cut_vertex_finder_core #(
    parameter int MAX_VERTICES = cvf_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cvf_pkg::ROW_W-1:0]         i_row_bits,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cvf_pkg::FIELD_W-1:0]       o_vertex_number,
    output logic                              o_is_cut,
    output logic [cvf_pkg::FIELD_W-1:0]       o_cut_total,
    output logic [cvf_pkg::FIELD_W-1:0]       o_base_components,
    output logic                              o_last_result,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cvf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cvf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cvf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int W  = MAX_VERTICES;
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int EW = (VW > cvf_pkg::FIELD_W) ? VW : cvf_pkg::FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXPAND = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    function automatic logic [IW-1:0] low_index(input logic [W-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int j = W - 1; j >= 0; j--) begin
            if (v[j]) idx = IW'(j);
        end
        return idx;
    endfunction

    t_state                    r_state, n_state;
    logic [cvf_pkg::FIELD_W-1:0] r_vertex_count, n_vertex_count;
    logic [VW-1:0]             r_rows_loaded, n_rows_loaded;
    logic [VW-1:0]             r_pass, n_pass;
    logic [VW-1:0]             r_comp, n_comp;
    logic [VW-1:0]             r_base, n_base;
    logic [VW-1:0]             r_cut, n_cut;
    logic [W-1:0]              r_visited, n_visited;
    logic [W-1:0]              r_pend, n_pend;
    logic                      r_rd_valid, n_rd_valid;
    logic [W-1:0]              r_rd_data;
    logic                      r_out_valid, n_out_valid;

    logic [W-1:0]              mem [W];

    logic [EW-1:0]             vc_ext;
    logic [VW-1:0]             act;
    logic [W-1:0]              vmask;
    logic [W-1:0]              row_ext;
    logic [W-1:0]              merge_new;
    logic [W-1:0]              unvisited;
    logic [W-1:0]              search;
    logic [IW-1:0]             pick;
    logic [W-1:0]              pick_bit;
    logic [VW-1:0]             row_idx;
    logic                      in_xfer;
    logic                      cfg_wr;
    logic                      out_free;
    logic                      out_load;
    logic                      is_cut;

    assign pready     = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite
                        && (paddr[cvf_pkg::APB_ADDR_W-1:2] == cvf_pkg::REG_VERTEX_COUNT);
    assign prdata     = (paddr[cvf_pkg::APB_ADDR_W-1:2] == cvf_pkg::REG_VERTEX_COUNT)
                        ? cvf_pkg::APB_DATA_W'(r_vertex_count) : '0;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == S_EMIT) && out_free;
    assign is_cut     = r_comp > r_base;
    assign o_out_valid = r_out_valid;

    always_comb begin
        vc_ext = EW'(r_vertex_count);
        if (vc_ext == '0) begin
            act = VW'(1);
        end else if (vc_ext > EW'(MAX_VERTICES)) begin
            act = VW'(MAX_VERTICES);
        end else begin
            act = VW'(vc_ext);
        end
        for (int j = 0; j < W; j++) begin
            vmask[j] = VW'(j) < act;
        end
    end

    assign row_ext   = W'(i_row_bits);
    assign merge_new = r_rd_valid ? (r_rd_data & vmask & ~r_visited) : '0;
    assign unvisited = ~r_visited & vmask;
    assign search    = (r_pend != '0) ? r_pend : unvisited;
    assign pick      = low_index(search);
    assign pick_bit  = W'(1) << pick;
    assign row_idx   = (r_rows_loaded >= act) ? '0 : r_rows_loaded;

    always_comb begin
        n_state        = r_state;
        n_vertex_count = r_vertex_count;
        n_rows_loaded  = r_rows_loaded;
        n_pass         = r_pass;
        n_comp         = r_comp;
        n_base         = r_base;
        n_cut          = r_cut;
        n_visited      = r_visited;
        n_pend         = r_pend;
        n_rd_valid     = 1'b0;
        n_out_valid    = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (VW'(row_idx + 1'b1) == act) begin
                        n_rows_loaded = '0;
                        n_pass        = '0;
                        n_comp        = '0;
                        n_cut         = '0;
                        n_visited     = '0;
                        n_pend        = '0;
                        n_state       = S_EXPAND;
                    end else begin
                        n_rows_loaded = VW'(row_idx + 1'b1);
                    end
                end
            end
            S_EXPAND: begin
                n_visited = r_visited | merge_new;
                n_pend    = r_pend | merge_new;
                if (r_pend != '0) begin
                    n_pend     = (r_pend & ~pick_bit) | merge_new;
                    n_rd_valid = 1'b1;
                end else if (r_rd_valid) begin
                    n_rd_valid = 1'b0;
                end else if (unvisited != '0) begin
                    n_visited = r_visited | pick_bit;
                    n_pend    = pick_bit;
                    n_comp    = VW'(r_comp + 1'b1);
                end else if (r_pass == '0) begin
                    n_base    = r_comp;
                    n_pass    = VW'(1);
                    n_visited = W'(1);
                    n_pend    = '0;
                    n_comp    = '0;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_cut       = VW'(r_cut + VW'(is_cut));
                    if (r_pass == act) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pass    = VW'(r_pass + 1'b1);
                        n_visited = W'(1) << r_pass[IW-1:0];
                        n_pend    = '0;
                        n_comp    = '0;
                        n_state   = S_EXPAND;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (cfg_wr) begin
            n_vertex_count = pwdata[cvf_pkg::FIELD_W-1:0];
            n_rows_loaded  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= cvf_pkg::VERTEX_COUNT_RST;
            r_rows_loaded  <= '0;
            r_pass         <= '0;
            r_comp         <= '0;
            r_base         <= '0;
            r_cut          <= '0;
            r_visited      <= '0;
            r_pend         <= '0;
            r_rd_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_vertex_count <= n_vertex_count;
            r_rows_loaded  <= n_rows_loaded;
            r_pass         <= n_pass;
            r_comp         <= n_comp;
            r_base         <= n_base;
            r_cut          <= n_cut;
            r_visited      <= n_visited;
            r_pend         <= n_pend;
            r_rd_valid     <= n_rd_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    // adjacency store: one write port for rows, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            mem[row_idx[IW-1:0]] <= row_ext & vmask;
        end
        r_rd_data <= mem[pick];
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_vertex_number   <= cvf_pkg::FIELD_W'(r_pass);
            o_is_cut          <= is_cut;
            o_cut_total       <= cvf_pkg::FIELD_W'(r_cut + VW'(is_cut));
            o_base_components <= cvf_pkg::FIELD_W'(r_base);
            o_last_result     <= (r_pass == act);
        end
    end

    a_visited_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXPAND) |-> ((r_visited & ~vmask) == '0))
        else $error("visited set holds vertices beyond the active count");

    a_comp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_comp <= act))
        else $error("component count exceeds vertex count");

    a_cut_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cut <= r_pass)
        else $error("cut count exceeds vertices examined");

    a_read_in_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == S_EXPAND))
        else $error("row read in flight outside expansion");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_pass == act)) |=> (r_state == S_IDLE && o_out_valid && o_last_result))
        else $error("final result did not return the sequencer to idle");

endmodule

// ===== tb/sv/tb_cut_vertex_finder_core.sv =====
// tb_cut_vertex_finder_core: self-checking testbench for cut_vertex_finder_core.
// Streams adjacency rows, predicts every per-vertex cut report from its own
// reachability model and checks each result transfer. Depends on cvf_pkg and the RTL.
module tb_cut_vertex_finder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_V         = cvf_pkg::MAX_VERTICES_DEF;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned TAIL_CYCLES   = (MAX_V + 1) * (MAX_V + 2) + 100;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam logic [cvf_pkg::APB_ADDR_W-1:0] VCOUNT_ADDR =
        {cvf_pkg::REG_VERTEX_COUNT, 2'b00};

    typedef struct packed {
        logic [cvf_pkg::FIELD_W-1:0] vertex_no;
        logic                        cut;
        logic [cvf_pkg::FIELD_W-1:0] cut_total;
        logic [cvf_pkg::FIELD_W-1:0] base_parts;
        logic                        last_one;
    } cut_report_t;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [cvf_pkg::ROW_W-1:0]        i_row_bits = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [cvf_pkg::FIELD_W-1:0]      o_vertex_number;
    logic                             o_is_cut;
    logic [cvf_pkg::FIELD_W-1:0]      o_cut_total;
    logic [cvf_pkg::FIELD_W-1:0]      o_base_components;
    logic                             o_last_result;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [cvf_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [cvf_pkg::APB_DATA_W-1:0]   pwdata = '0;
    logic [cvf_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    // predictor state
    logic [31:0]       adj_rows [MAX_V];
    logic [31:0]       trial_graph [MAX_V];
    int unsigned       rows_have = 0;
    logic [5:0]        vcount_reg = 6'd32;
    cut_report_t       pending_reports [$];

    int unsigned       send_idle_pct = 0;
    int unsigned       stall_pct = 0;
    int unsigned       errors = 0;
    int unsigned       cycles = 0;

    cut_vertex_finder_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_row_bits        (i_row_bits),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_vertex_number   (o_vertex_number),
        .o_is_cut          (o_is_cut),
        .o_cut_total       (o_cut_total),
        .o_base_components (o_base_components),
        .o_last_result     (o_last_result),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (errors < 100)
            $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    function automatic int unsigned live_vertices();
        if (vcount_reg == 6'd0)
            return 1;
        if (vcount_reg > MAX_V)
            return MAX_V;
        return vcount_reg;
    endfunction

    function automatic logic [31:0] vertex_mask(input int unsigned v);
        logic [63:0] m;
        m = (64'd1 << v) - 64'd1;
        return m[31:0];
    endfunction

    // components among vertices not in the removed set
    function automatic int unsigned count_parts(input int unsigned v, input logic [31:0] removed);
        logic [31:0] seen, wave, grow;
        int unsigned parts;
        seen  = removed;
        parts = 0;
        for (int s = 0; s < v; s++) begin
            if (!seen[s]) begin
                parts++;
                seen[s] = 1'b1;
                wave = 32'd1 << s;
                while (wave != 0) begin
                    grow = '0;
                    for (int i = 0; i < v; i++)
                        if (wave[i])
                            grow |= adj_rows[i];
                    grow &= vertex_mask(v) & ~seen;
                    seen |= grow;
                    wave  = grow;
                end
            end
        end
        return parts;
    endfunction

    function automatic void accept_row(input logic [31:0] row);
        int unsigned v, base, parts, total;
        cut_report_t r;
        v = live_vertices();
        if (rows_have >= v)
            rows_have = 0;
        adj_rows[rows_have] = row & vertex_mask(v);
        rows_have++;
        if (rows_have < v)
            return;
        rows_have = 0;
        base  = count_parts(v, '0);
        total = 0;
        for (int u = 0; u < v; u++) begin
            parts = count_parts(v, 32'd1 << u);
            r.cut = (parts > base);
            if (r.cut)
                total++;
            r.vertex_no  = 6'(u + 1);
            r.cut_total  = 6'(total);
            r.base_parts = 6'(base);
            r.last_one   = (u + 1 == v);
            pending_reports = {pending_reports, r};
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        cut_report_t want;
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result for vertex %0d", o_vertex_number));
            end else begin
                want = pending_reports.pop_front();
                if (o_vertex_number !== want.vertex_no)
                    report_mismatch($sformatf("vertex_number %0d, want %0d",
                        o_vertex_number, want.vertex_no));
                if (o_is_cut !== want.cut)
                    report_mismatch($sformatf("is_cut %b, want %b (vertex %0d)",
                        o_is_cut, want.cut, want.vertex_no));
                if (o_cut_total !== want.cut_total)
                    report_mismatch($sformatf("cut_total %0d, want %0d (vertex %0d)",
                        o_cut_total, want.cut_total, want.vertex_no));
                if (o_base_components !== want.base_parts)
                    report_mismatch($sformatf("base_components %0d, want %0d (vertex %0d)",
                        o_base_components, want.base_parts, want.vertex_no));
                if (o_last_result !== want.last_one)
                    report_mismatch($sformatf("last_result %b, want %b (vertex %0d)",
                        o_last_result, want.last_one, want.vertex_no));
            end
        end
    end

    // valid stays high after the transfer; the next send or a drain moves it
    task automatic send_row(input logic [31:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_row_bits <= row;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        accept_row(row);
    endtask

    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure_vertices(input logic [31:0] value);
        logic [31:0] got;
        wait_until_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VCOUNT_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        vcount_reg = value[5:0];
        rows_have  = 0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[5:0] !== value[5:0])
            report_mismatch($sformatf("vertex_count read %0d, want %0d", got[5:0], value[5:0]));
    endtask

    // random graph: noise, sparse tree with extra edges, or random density
    function automatic void fill_trial_graph(input int unsigned v);
        int unsigned shape, density, a, b;
        shape   = $urandom_range(9);
        density = $urandom_range(60, 2);
        foreach (trial_graph[i])
            trial_graph[i] = '0;
        if (shape < 2) begin
            foreach (trial_graph[i])
                trial_graph[i] = $urandom;
        end else begin
            if (shape < 6) begin
                for (int i = 1; i < v; i++) begin
                    if ($urandom_range(9) != 0) begin
                        a = $urandom_range(i - 1);
                        trial_graph[i][a] = 1'b1;
                        trial_graph[a][i] = 1'b1;
                    end
                end
                repeat ($urandom_range(3)) begin
                    a = $urandom_range(v - 1);
                    b = $urandom_range(v - 1);
                    trial_graph[a][b] = 1'b1;
                    trial_graph[b][a] = 1'b1;
                end
            end else begin
                for (int i = 0; i < v; i++)
                    for (int j = i + 1; j < v; j++)
                        if ($urandom_range(99) < density) begin
                            trial_graph[i][j] = 1'b1;
                            trial_graph[j][i] = 1'b1;
                        end
            end
            for (int i = 0; i < v; i++) begin
                if ($urandom_range(9) == 0)
                    trial_graph[i][i] = 1'b1;
                if ($urandom_range(1) == 0)
                    trial_graph[i] |= $urandom & ~vertex_mask(v);
            end
            if ($urandom_range(9) == 0) begin
                a = $urandom_range(v - 1);
                b = $urandom_range(v - 1);
                trial_graph[a][b] = ~trial_graph[a][b];
            end
        end
    endfunction

    task automatic run_phase(input int unsigned idle_pct, input int unsigned hold_pct,
                             input logic [5:0] vreg, input int unsigned n_rows,
                             input bit pause_each);
        int unsigned v, sent;
        configure_vertices({26'($urandom_range(32'h03FF_FFFF)), vreg});
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        v    = live_vertices();
        sent = 0;
        while (sent < n_rows) begin
            fill_trial_graph(v);
            for (int i = 0; i < v && sent < n_rows; i++) begin
                send_row(trial_graph[i]);
                sent++;
            end
            if (pause_each)
                wait_until_drained();
        end
    endtask

    task automatic test_single_vertex();
        configure_vertices(32'd0);
        send_row(32'hFFFF_FFFF);
        send_row(32'h0000_0000);
    endtask

    task automatic test_path_and_star_reload();
        configure_vertices(32'd3);
        send_row(32'h0000_0002);
        send_row(32'h0000_0005);
        send_row(32'h0000_0002);
        // two rows loaded, then the register write restarts the matrix
        configure_vertices(32'd4);
        send_row(32'h0000_0001);
        send_row(32'h0000_0008);
        configure_vertices(32'd4);
        send_row(32'hFFFF_FFFE);
        send_row(32'hFFFF_FFF1);
        send_row(32'h0000_0001);
        send_row(32'h0000_0001);
    endtask

    task automatic test_one_way_edge();
        configure_vertices(32'd2);
        send_row(32'h0000_0002);
        send_row(32'h0000_0000);
    endtask

    task automatic test_bowtie_and_complete();
        configure_vertices(32'd5);
        send_row(32'h0000_0006);
        send_row(32'h0000_0005);
        send_row(32'h0000_001B);
        send_row(32'h0000_0014);
        send_row(32'h0000_000C);
        repeat (5) send_row(32'hFFFF_FFFF);
    endtask

    task automatic test_random_phases();
        run_phase(0,  0,  6'd32, 64, 1'b0);
        run_phase(84, 0,  6'd5,  50, 1'b0);
        run_phase(0,  84, 6'd63, 64, 1'b0);
        run_phase(30, 30, 6'd1,  30, 1'b0);
        run_phase(30, 30, 6'($urandom_range(31, 2)), 50, 1'b0);
        run_phase(0,  84, 6'd8,  40, 1'b0);
        run_phase(84, 0,  6'd17, 34, 1'b0);
    endtask

    task automatic test_pause_until_drained();
        run_phase(30, 30, 6'd6, 24, 1'b1);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_vertex();
        test_path_and_star_reload();
        test_one_way_edge();
        test_bowtie_and_complete();
        test_random_phases();
        test_pause_until_drained();
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cvf_pkg.sv
rtl/cut_vertex_finder_core.sv
tb/sv/tb_cut_vertex_finder_core.sv
